@@ hw/rtl/ir_pulse_pattern_volume_control_defines.svh @@
// Assertion macros shared by the IR pulse pattern volume control RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef IR_PULSE_PATTERN_VOLUME_CONTROL_DEFINES_SVH
`define IR_PULSE_PATTERN_VOLUME_CONTROL_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IPPVC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define IPPVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ippvc_pkg.sv @@
// Types, constants and helper functions for the IR pulse pattern volume control.
// Depends on nothing.
package ippvc_pkg;

  localparam int TICKS_W  = 16;
  localparam int TOL_W    = 8;
  localparam int EXP_W    = 10;
  localparam int POS_W    = 8;
  localparam int VOL_W    = 7;
  localparam int CODE_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WORD_SLOTS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_LIMIT = 3'd4;

  localparam logic [TOL_W-1:0]   TOLERANCE_RST    = 8'd19;
  localparam logic [EXP_W-1:0]   SHORT_TICKS_RST  = 10'd33;
  localparam logic [EXP_W-1:0]   LONG_TICKS_RST   = 10'd67;
  localparam logic [TICKS_W-1:0] PAUSE_TICKS_RST  = 16'd375;
  localparam logic [VOL_W-1:0]   VOLUME_LIMIT_RST = 7'd100;

  localparam logic [CODE_W-1:0] CODE_UP_A    = 3'd0;
  localparam logic [CODE_W-1:0] CODE_UP_B    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_DOWN_A  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_DOWN_B  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_MUTE_ON  = 3'd4;
  localparam logic [CODE_W-1:0] CODE_MUTE_OFF = 3'd5;

  localparam logic [7:0] BUTTON_WORDS [WORD_SLOTS] = '{
    8'h19, 8'h1C, 8'h9C, 8'h99, 8'hE4, 8'hE1, 8'h00, 8'h00
  };

  typedef struct packed {
    logic              button_valid;
    logic [CODE_W-1:0] button_code;
    logic [VOL_W-1:0]  step_count;
    logic              step_up;
    logic              muted;
    logic [VOL_W-1:0]  volume;
  } result_t;

  // long pulse expected at this position for this pattern word
  function automatic logic pattern_long(input logic [7:0] word, input logic [POS_W-1:0] pos);
    logic [2:0] idx;
    logic       hit;
    idx = 3'd0;
    hit = 1'b0;
    if (pos >= 8'd2 && pos <= 8'd4) begin
      idx = 3'(pos - 8'd2);
      hit = 1'b1;
    end else if (pos >= 8'd15 && pos <= 8'd17) begin
      idx = 3'(pos - 8'd12);
      hit = 1'b1;
    end else if (pos >= 8'd20 && pos <= 8'd21) begin
      idx = 3'(pos - 8'd14);
      hit = 1'b1;
    end
    return hit & word[idx];
  endfunction

  // |d - e| <= tol, lower edge clipped at zero
  function automatic logic in_window(input logic [TICKS_W-1:0] d, input logic [EXP_W-1:0] e,
                                     input logic [TOL_W-1:0] tol);
    logic [EXP_W:0]   hi;
    logic [EXP_W-1:0] lo;
    hi = {1'b0, e} + {3'b000, tol};
    lo = (e > {2'b00, tol}) ? e - {2'b00, tol} : '0;
    return (d >= {6'b0, lo}) && (d <= {5'b0, hi});
  endfunction

endpackage

@@ hw/rtl/ippvc_pulse_if.sv @@
// Edge event channel: valid/ready handshake with pulse duration and pin level.
// Depends on ippvc_pkg.
interface ippvc_pulse_if;
  import ippvc_pkg::*;
  logic               valid;
  logic               ready;
  logic [TICKS_W-1:0] pulse_ticks;
  logic               pin_level;

  modport source (output valid, output pulse_ticks, output pin_level, input ready);
  modport sink (input valid, input pulse_ticks, input pin_level, output ready);
endinterface

@@ hw/rtl/ippvc_report_if.sv @@
// Result channel: valid/ready handshake with button and volume controller report.
// Depends on ippvc_pkg.
interface ippvc_report_if;
  import ippvc_pkg::*;
  logic              valid;
  logic              ready;
  logic              button_valid;
  logic [CODE_W-1:0] button_code;
  logic [VOL_W-1:0]  step_count;
  logic              step_up;
  logic              muted;
  logic [VOL_W-1:0]  volume;

  modport source (output valid, output button_valid, output button_code, output step_count,
                  output step_up, output muted, output volume, input ready);
  modport sink (input valid, input button_valid, input button_code, input step_count,
                input step_up, input muted, input volume, output ready);
endinterface

@@ hw/rtl/ir_pulse_pattern_volume_control.sv @@
// IR remote frame matcher with volume and mute controller, top level.
// Depends on ippvc_pkg, ippvc_pulse_if, ippvc_report_if and the defines header.
// A result is registered and presented in the cycle after its edge event transfers.
// Throughput: 1 item per cycle; the single result register accepts a new item
//   whenever it is empty or being drained in the same cycle.
// Reset (rst, synchronous): position 0, all patterns live, volume 0, unmuted,
//   registers to their defaults, result register empty.
`include "ir_pulse_pattern_volume_control_defines.svh"
module ir_pulse_pattern_volume_control #(
  parameter int FRAME_EDGES   = 23,
  parameter int PATTERN_COUNT = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  ippvc_pulse_if.sink                        pulse,
  ippvc_report_if.source                     report,
  input  logic                               cfg_wen,
  input  logic [ippvc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ippvc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ippvc_pkg::*;

  localparam logic [PATTERN_COUNT-1:0] ALL_LIVE = {PATTERN_COUNT{1'b1}};

  logic [TOL_W-1:0]   tolerance;
  logic [EXP_W-1:0]   short_ticks;
  logic [EXP_W-1:0]   long_ticks;
  logic [TICKS_W-1:0] pause_ticks;
  logic [VOL_W-1:0]   volume_limit;

  logic [POS_W-1:0]         position, position_next;
  logic [PATTERN_COUNT-1:0] live, live_next;
  logic [VOL_W-1:0]         volume_level, volume_level_next;
  logic                     mute_flag, mute_flag_next;

  logic    out_full;
  result_t out_data, out_data_next;

  logic                     accept;
  logic                     ok_short, ok_long, level_ok;
  logic [PATTERN_COUNT-1:0] pattern_ok;

  assign pulse.ready = !out_full || report.ready;
  assign accept      = pulse.valid && pulse.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance    <= TOLERANCE_RST;
      short_ticks  <= SHORT_TICKS_RST;
      long_ticks   <= LONG_TICKS_RST;
      pause_ticks  <= PAUSE_TICKS_RST;
      volume_limit <= VOLUME_LIMIT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_TOLERANCE:    tolerance    <= cfg_data[TOL_W-1:0];
        REG_SHORT_TICKS:  short_ticks  <= cfg_data[EXP_W-1:0];
        REG_LONG_TICKS:   long_ticks   <= cfg_data[EXP_W-1:0];
        REG_PAUSE_TICKS:  pause_ticks  <= cfg_data[TICKS_W-1:0];
        REG_VOLUME_LIMIT: volume_limit <= cfg_data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign ok_short = in_window(pulse.pulse_ticks, short_ticks, tolerance);
  assign ok_long  = in_window(pulse.pulse_ticks, long_ticks, tolerance);
  assign level_ok = pulse.pin_level != position[0];

  for (genvar g = 0; g < PATTERN_COUNT; g++) begin : g_pattern
    assign pattern_ok[g] = level_ok &&
        (pattern_long(BUTTON_WORDS[g], position) ? ok_long : ok_short);
  end

  always_comb begin
    logic              btn_valid;
    logic [CODE_W-1:0] btn_code;
    logic [VOL_W-1:0]  steps;
    logic              up;
    position_next     = position;
    live_next         = live;
    volume_level_next = volume_level;
    mute_flag_next    = mute_flag;
    btn_valid         = 1'b0;
    btn_code          = '0;
    steps             = '0;
    up                = 1'b0;

    if (pulse.pulse_ticks > pause_ticks) begin
      position_next = '0;
      live_next     = ALL_LIVE;
    end else if (live != '0) begin
      live_next     = live & pattern_ok;
      position_next = position + 8'd1;
      if (position_next == POS_W'(FRAME_EDGES) && $onehot(live_next)) begin
        btn_valid = 1'b1;
        for (int i = 0; i < PATTERN_COUNT; i++) begin
          if (live_next[i]) btn_code = CODE_W'(i);
        end
      end
    end

    if (btn_valid) begin
      unique case (btn_code)
        CODE_UP_A, CODE_UP_B: begin
          if (volume_level < volume_limit && !mute_flag) begin
            steps = 7'd1;
            up    = 1'b1;
            volume_level_next = volume_level + 7'd1;
          end
        end
        CODE_DOWN_A, CODE_DOWN_B: begin
          if (volume_level != '0 && !mute_flag) begin
            steps = 7'd1;
            volume_level_next = volume_level - 7'd1;
          end
        end
        CODE_MUTE_ON: begin
          if (!mute_flag) begin
            mute_flag_next = 1'b1;
            steps = volume_level;
          end
        end
        CODE_MUTE_OFF: begin
          if (mute_flag) begin
            mute_flag_next = 1'b0;
            steps = volume_level;
            up    = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (steps == '0) up = 1'b0;

    out_data_next.button_valid = btn_valid;
    out_data_next.button_code  = btn_code;
    out_data_next.step_count   = steps;
    out_data_next.step_up      = up;
    out_data_next.muted        = mute_flag_next;
    out_data_next.volume       = volume_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      live         <= ALL_LIVE;
      volume_level <= '0;
      mute_flag    <= 1'b0;
      out_full     <= 1'b0;
    end else begin
      if (accept) begin
        position     <= position_next;
        live         <= live_next;
        volume_level <= volume_level_next;
        mute_flag    <= mute_flag_next;
        out_full     <= 1'b1;
      end else if (report.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
    end
  end

  assign report.valid        = out_full;
  assign report.button_valid = out_data.button_valid;
  assign report.button_code  = out_data.button_code;
  assign report.step_count   = out_data.step_count;
  assign report.step_up      = out_data.step_up;
  assign report.muted        = out_data.muted;
  assign report.volume       = out_data.volume;

  `IPPVC_ASSERT_NOW(a_button_at_frame_end, clk, rst, out_full && out_data.button_valid, position == POS_W'(FRAME_EDGES), "button reported away from frame end")
  `IPPVC_ASSERT_NOW(a_button_single_live, clk, rst, out_full && out_data.button_valid, $onehot(live), "button reported without exactly one live pattern")
  `IPPVC_ASSERT_NOW(a_steps_need_button, clk, rst, out_full && out_data.step_count != '0, out_data.button_valid, "steps reported without a button")
  `IPPVC_ASSERT_NEXT(a_pause_rearms, clk, rst, accept && pulse.pulse_ticks > pause_ticks, position == '0 && live == ALL_LIVE, "pause gap did not restart matching")

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for ir_pulse_pattern_volume_control: random IR edge frames, register phases.
// Depends on ippvc_pkg, ippvc_pulse_if, ippvc_report_if and the block's RTL.
module tb_top;
  import ippvc_pkg::*;

  localparam int FRAME_EDGES = 23;
  localparam int KEY_COUNT   = 6;
  localparam int STUCK_LIMIT = 2000;
  localparam int PHASE_COUNT = 7;
  localparam int REG_COUNT   = 5;

  localparam logic [7:0] KEY_WORDS [KEY_COUNT] = '{8'h19, 8'h1C, 8'h9C, 8'h99, 8'hE4, 8'hE1};

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [REG_COUNT] = '{
    REG_TOLERANCE, REG_SHORT_TICKS, REG_LONG_TICKS, REG_PAUSE_TICKS, REG_VOLUME_LIMIT
  };

  localparam int PHASE_REGS [PHASE_COUNT][REG_COUNT] = '{
    '{19, 33, 67, 375, 100},
    '{0, 10, 20, 40, 3},
    '{255, 33, 67, 375, 127},
    '{5, 1023, 0, 65535, 0},
    '{2, 0, 1023, 0, 127},
    '{8, 30, 90, 500, 2},
    '{19, 33, 67, 375, 100}
  };
  localparam int PHASE_MODE  [PHASE_COUNT] = '{0, 1, 2, 3, 0, 1, 3};
  localparam int PHASE_EDGES [PHASE_COUNT] = '{260, 190, 100, 60, 60, 150, 110};

  // {pin_level, pulse_ticks}
  localparam int PROBE_COUNT = 15;
  localparam logic [16:0] PROBES [PROBE_COUNT] = '{
    {1'b1, 16'd65535}, {1'b0, 16'd0}, {1'b0, 16'd376}, {1'b1, 16'd375}, {1'b1, 16'd376},
    {1'b1, 16'd14}, {1'b0, 16'd52}, {1'b1, 16'd53}, {1'b0, 16'd87}, {1'b0, 16'd376},
    {1'b1, 16'd13}, {1'b0, 16'hAAAA}, {1'b1, 16'h5555}, {1'b0, 16'd376}, {1'b1, 16'd33}
  };

  class frame_volume_tracker;
    logic [TOL_W-1:0]   tolerance;
    logic [EXP_W-1:0]   short_ticks;
    logic [EXP_W-1:0]   long_ticks;
    logic [TICKS_W-1:0] pause_ticks;
    logic [VOL_W-1:0]   volume_limit;
    logic [POS_W-1:0]   position;
    logic [KEY_COUNT-1:0] live;
    logic [VOL_W-1:0]   volume;
    logic               muted;
    result_t            reports_due[$];
    int                 errors;
    int                 edges;
    int                 buttons;
    int                 steps;

    function new();
      tolerance    = 8'd19;
      short_ticks  = 10'd33;
      long_ticks   = 10'd67;
      pause_ticks  = 16'd375;
      volume_limit = 7'd100;
      position     = '0;
      live         = '1;
      volume       = '0;
      muted        = 1'b0;
      errors       = 0;
      edges        = 0;
      buttons      = 0;
      steps        = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_TOLERANCE:    tolerance    = value[TOL_W-1:0];
        REG_SHORT_TICKS:  short_ticks  = value[EXP_W-1:0];
        REG_LONG_TICKS:   long_ticks   = value[EXP_W-1:0];
        REG_PAUSE_TICKS:  pause_ticks  = value[TICKS_W-1:0];
        REG_VOLUME_LIMIT: volume_limit = value[VOL_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned target(int key, logic [POS_W-1:0] pos);
      int b;
      case (pos)
        8'd2, 8'd3, 8'd4:    b = pos - 2;
        8'd15, 8'd16, 8'd17: b = pos - 12;
        8'd20, 8'd21:        b = pos - 14;
        default: return short_ticks;
      endcase
      return KEY_WORDS[key][b] ? long_ticks : short_ticks;
    endfunction

    function bit fits(int unsigned d, int unsigned e);
      int unsigned lo;
      lo = (e > tolerance) ? e - tolerance : 0;
      return d >= lo && d <= e + tolerance;
    endfunction

    function void note_edge(logic [TICKS_W-1:0] ticks, logic level);
      result_t r;
      r = '0;
      edges++;
      if (ticks > pause_ticks) begin
        position = '0;
        live = '1;
      end else if (live != '0) begin
        for (int k = 0; k < KEY_COUNT; k++) begin
          if (live[k] && !(level != position[0] && fits(ticks, target(k, position)))) begin
            live[k] = 1'b0;
          end
        end
        position = position + 1'b1;
        if (position == FRAME_EDGES) begin
          for (int k = 0; k < KEY_COUNT; k++) begin
            if (live == (1 << k)) begin
              r.button_valid = 1'b1;
              r.button_code = CODE_W'(k);
            end
          end
        end
      end
      if (r.button_valid) begin
        buttons++;
        case (r.button_code)
          CODE_UP_A, CODE_UP_B: begin
            if (volume < volume_limit && !muted) begin
              r.step_count = 7'd1;
              r.step_up = 1'b1;
              volume = volume + 1'b1;
            end
          end
          CODE_DOWN_A, CODE_DOWN_B: begin
            if (volume > 0 && !muted) begin
              r.step_count = 7'd1;
              volume = volume - 1'b1;
            end
          end
          CODE_MUTE_ON: begin
            if (!muted) begin
              muted = 1'b1;
              r.step_count = volume;
            end
          end
          CODE_MUTE_OFF: begin
            if (muted) begin
              muted = 1'b0;
              r.step_count = volume;
              r.step_up = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (r.step_count == 0) r.step_up = 1'b0;
      r.muted = muted;
      r.volume = volume;
      steps += r.step_count;
      reports_due.push_back(r);
    endfunction

    function void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (reports_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, actual %h", $time, got);
        return;
      end
      want = reports_due.pop_front();
      check_field("button_valid", want.button_valid, got.button_valid);
      check_field("button_code", want.button_code, got.button_code);
      check_field("step_count", want.step_count, got.step_count);
      check_field("step_up", want.step_up, got.step_up);
      check_field("muted", want.muted, got.muted);
      check_field("volume", want.volume, got.volume);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int idle_mode = 0;
  int edges_sent = 0;
  frame_volume_tracker board = new();

  ippvc_pulse_if  pulse ();
  ippvc_report_if report ();

  ir_pulse_pattern_volume_control u_dut (
    .clk       (clk),
    .rst       (rst),
    .pulse     (pulse),
    .report    (report),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit sender_holds();
    return (idle_mode == 1 && roll(56)) || (idle_mode == 3 && roll(9));
  endfunction

  always @(negedge clk) begin
    report.ready <= !((idle_mode == 2 && roll(56)) || (idle_mode == 3 && roll(9)));
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pulse.valid && pulse.ready) board.note_edge(pulse.pulse_ticks, pulse.pin_level);
      if (report.valid && report.ready) begin
        board.check_report(result_t'({report.button_valid, report.button_code, report.step_count,
                                      report.step_up, report.muted, report.volume}));
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((pulse.valid && pulse.ready) || (report.valid && report.ready)) stuck = 0;
      else stuck++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_edge(logic [TICKS_W-1:0] ticks, logic level);
    @(negedge clk);
    while (sender_holds()) begin
      pulse.valid = 1'b0;
      @(negedge clk);
    end
    pulse.valid = 1'b1;
    pulse.pulse_ticks = ticks;
    pulse.pin_level = level;
    do @(posedge clk); while (!pulse.ready);
    edges_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    pulse.valid = 1'b0;
    while (board.reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic apply_setting(int ph);
    drain();
    for (int r = 0; r < REG_COUNT; r++) begin
      @(negedge clk);
      cfg_wen = 1'b1;
      cfg_index = REG_ORDER[r];
      cfg_data = CFG_DATA_W'(PHASE_REGS[ph][r]);
      @(posedge clk);
      board.set_register(REG_ORDER[r], CFG_DATA_W'(PHASE_REGS[ph][r]));
    end
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  function automatic logic [TICKS_W-1:0] near_target(int unsigned e);
    int unsigned span;
    int unsigned lo;
    int unsigned hi;
    span = roll(25) ? board.tolerance : ((board.tolerance < 3) ? board.tolerance : 3);
    lo = (e > span) ? e - span : 0;
    hi = e + span;
    if (hi > board.pause_ticks) hi = (board.pause_ticks >= lo) ? board.pause_ticks : lo;
    return TICKS_W'($urandom_range(hi, lo));
  endfunction

  task automatic send_gap();
    int unsigned p;
    int unsigned top;
    p = board.pause_ticks;
    top = (p + 40 > 65535) ? 65535 : p + 40;
    if (p == 65535) send_edge(TICKS_W'($urandom_range(65535)), 1'($urandom_range(1)));
    else if (roll(50)) send_edge(TICKS_W'($urandom_range(top, p + 1)), 1'($urandom_range(1)));
    else send_edge(TICKS_W'($urandom_range(65535, p + 1)), 1'($urandom_range(1)));
  endtask

  task automatic send_frame(int key, int edges, int broken_at);
    int unsigned e;
    logic [TICKS_W-1:0] d;
    logic lvl;
    logic [POS_W-1:0] pos;
    send_gap();
    for (int n = 0; n < edges; n++) begin
      pos = POS_W'(n);
      e = board.target(key, pos);
      d = near_target(e);
      lvl = ~pos[0];
      if (n == broken_at) begin
        if (roll(50)) lvl = pos[0];
        else d = TICKS_W'(e + board.tolerance + 1 + $urandom_range(20));
      end
      send_edge(d, lvl);
    end
  endtask

  task automatic random_sequence();
    int pick;
    int extra;
    pick = $urandom_range(99);
    extra = roll(15) ? $urandom_range(6, 1) : 0;
    if (pick < 64) begin
      send_frame($urandom_range(KEY_COUNT - 1), FRAME_EDGES + extra, -1);
    end else if (pick < 76) begin
      send_frame($urandom_range(KEY_COUNT - 1), FRAME_EDGES, $urandom_range(FRAME_EDGES - 1));
    end else if (pick < 78) begin
      drain();
    end else begin
      repeat ($urandom_range(6, 1)) begin
        send_edge(roll(50) ? TICKS_W'($urandom_range(65535)) : TICKS_W'($urandom_range(120)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int stop;
    pulse.valid = 1'b0;
    pulse.pulse_ticks = '0;
    pulse.pin_level = 1'b0;
    report.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      idle_mode = PHASE_MODE[ph];
      apply_setting(ph);
      if (ph == 0) begin
        for (int i = 0; i < PROBE_COUNT; i++) send_edge(PROBES[i][15:0], PROBES[i][16]);
        // run one frame all the way round the position counter
        send_frame($urandom_range(KEY_COUNT - 1), FRAME_EDGES + 256, -1);
      end
      stop = edges_sent + PHASE_EDGES[ph];
      while (edges_sent < stop) random_sequence();
    end
    drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d edge transfers over %0d register settings, %0d button frames,",
             board.edges, PHASE_COUNT, board.buttons);
    $display("  %0d step pulses; final volume %0d, muted %0d",
             board.steps, board.volume, board.muted);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
